[sv/vector3_normalize_defines.svh]
// Assertion macros used by the checker file of the vector normalizer.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH

// Implication in the same cycle, off while reset is held.
`define VN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vector3_normalize: check failed");

// Implication in the next cycle, checked also during reset.
`define VN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("vector3_normalize: check failed");

`endif

[sv/vn_pkg.sv]
package vn_pkg;

    // Default component width of the Q16.16 inputs.
    localparam int unsigned VN_COMPONENT_WIDTH = 32;
    // Default fraction bits of the unit vector result.
    localparam int unsigned VN_UNIT_FRACTION_BITS = 30;
    // Fixed widths of the stream fields.
    localparam int unsigned VN_FIELD_WIDTH = 32;
    localparam int unsigned VN_IN_DATA_WIDTH = 3 * VN_FIELD_WIDTH;
    localparam int unsigned VN_OUT_DATA_WIDTH = 4 * VN_FIELD_WIDTH;

endpackage

[sv/vn_sqrt_cell.sv]
module vn_sqrt_cell #(
    parameter int unsigned CW = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*CW-1:0]   i_sum,
    input  logic [CW+1:0]     i_rem,
    input  logic [CW-1:0]     i_root,
    input  logic [2:0][CW-1:0] i_mag,
    input  logic [2:0]        i_neg,
    output logic              o_valid,
    output logic [2*CW-1:0]   o_sum,
    output logic [CW+1:0]     o_rem,
    output logic [CW-1:0]     o_root,
    output logic [2:0][CW-1:0] o_mag,
    output logic [2:0]        o_neg
);
    logic [CW+3:0] w_rem_in;
    logic [CW+3:0] w_trial;
    logic [CW+3:0] w_diff;
    logic          w_ge;
    logic          r_valid;
    logic [2*CW-1:0] r_sum;
    logic [CW+1:0] r_rem;
    logic [CW-1:0] r_root;
    logic [2:0][CW-1:0] r_mag;
    logic [2:0]    r_neg;

    // One digit of the square root: bring down two bits and try the next root bit.
    assign w_rem_in = {i_rem, i_sum[2*CW-1 -: 2]};
    assign w_trial  = {2'b00, i_root, 2'b01};
    assign w_ge     = (w_rem_in >= w_trial);
    assign w_diff   = w_rem_in - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= {i_sum[2*CW-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[CW+1:0] : w_rem_in[CW+1:0];
            r_root <= {i_root[CW-2:0], w_ge};
            r_mag  <= i_mag;
            r_neg  <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule

[sv/vn_div_cell.sv]
module vn_div_cell #(
    parameter int unsigned CW = 32,
    parameter int unsigned FB = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [CW-1:0]     i_len,
    input  logic [2:0][CW:0]  i_rem,
    input  logic [2:0][FB:0]  i_quo,
    input  logic [2:0]        i_neg,
    output logic              o_valid,
    output logic [CW-1:0]     o_len,
    output logic [2:0][CW:0]  o_rem,
    output logic [2:0][FB:0]  o_quo,
    output logic [2:0]        o_neg
);
    logic [2:0][CW:0] w_diff;
    logic [2:0]       w_ge;
    logic             r_valid;
    logic [CW-1:0]    r_len;
    logic [2:0][CW:0] r_rem;
    logic [2:0][FB:0] r_quo;
    logic [2:0]       r_neg;

    // One quotient bit per lane: compare with the length and subtract.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ge[i]   = (i_rem[i] >= {1'b0, i_len});
            w_diff[i] = i_rem[i] - {1'b0, i_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= i_len;
            r_neg <= i_neg;
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= w_ge[i] ? {w_diff[i][CW-1:0], 1'b0} : {i_rem[i][CW-1:0], 1'b0};
                r_quo[i] <= {i_quo[i][FB-1:0], w_ge[i]};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_neg   = r_neg;

endmodule

[sv/vector3_normalize.sv]
// Channel   Direction  tdata (lowest bits first)              tuser
// s_axis    in         vec_x, vec_y, vec_z (32 bits each)     -
// m_axis    out        unit_x, unit_y, unit_z, magnitude      zero_vector
//
// One vector is accepted per cycle while the output is not stalled; a vector passes the square
// and sum registers, the chain of square root cells (one root bit each), the chain of
// divider cells (one quotient bit for all three lanes each) and the output register.
// Reset clears only the valid bits of the chain.
// The whole chain stalls only while the output register holds a transaction not yet taken.
module vector3_normalize #(
    parameter int unsigned COMPONENT_WIDTH    = vn_pkg::VN_COMPONENT_WIDTH,
    parameter int unsigned UNIT_FRACTION_BITS = vn_pkg::VN_UNIT_FRACTION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vec_x [31:0], vec_y [63:32], vec_z [95:64]
    input  logic [vn_pkg::VN_IN_DATA_WIDTH-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // unit_x [31:0], unit_y [63:32], unit_z [95:64], magnitude [127:96]
    output logic [vn_pkg::VN_OUT_DATA_WIDTH-1:0] m_axis_tdata,
    // zero_vector [0]
    output logic                                m_axis_tuser
);
    import vn_pkg::*;

    localparam int unsigned CW = COMPONENT_WIDTH;
    localparam int unsigned FB = UNIT_FRACTION_BITS;
    localparam int unsigned FW = VN_FIELD_WIDTH;

    logic w_en;

    // Input split into sign and magnitude.
    logic [2:0][CW-1:0] w_in_mag;
    logic [2:0]         w_in_neg;

    logic               r_sq_valid;
    logic [2:0][2*CW-1:0] r_sq;
    logic [2:0][CW-1:0] r_sq_mag;
    logic [2:0]         r_sq_neg;

    logic               r_sum_valid;
    logic [2*CW-1:0]    r_sum;
    logic [2:0][CW-1:0] r_sum_mag;
    logic [2:0]         r_sum_neg;

    logic               w_sv   [0:CW];
    logic [2*CW-1:0]    w_ssum [0:CW];
    logic [CW+1:0]      w_srem [0:CW];
    logic [CW-1:0]      w_sroot[0:CW];
    logic [2:0][CW-1:0] w_smag [0:CW];
    logic [2:0]         w_sneg [0:CW];

    logic               w_dv   [0:FB+1];
    logic [CW-1:0]      w_dlen [0:FB+1];
    logic [2:0][CW:0]   w_drem [0:FB+1];
    logic [2:0][FB:0]   w_dquo [0:FB+1];
    logic [2:0]         w_dneg [0:FB+1];

    logic               r_out_valid;
    logic [2:0][FW-1:0] r_unit;
    logic [FW-1:0]      r_mag_out;
    logic               r_zero;
    logic [2:0][FW-1:0] w_unit;

    // The chain advances unless the output transaction is stalled.
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_in_neg[i] = s_axis_tdata[i*FW + CW - 1];
            w_in_mag[i] = w_in_neg[i] ? (CW'(0) - s_axis_tdata[i*FW +: CW])
                                      : s_axis_tdata[i*FW +: CW];
        end
    end

    // Squares of the three magnitudes, then their sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_sum_valid <= 1'b0;
        end else if (w_en) begin
            r_sq_valid  <= s_axis_tvalid;
            r_sum_valid <= r_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= w_in_mag[i] * w_in_mag[i];
            end
            r_sq_mag  <= w_in_mag;
            r_sq_neg  <= w_in_neg;
            r_sum     <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sum_mag <= r_sq_mag;
            r_sum_neg <= r_sq_neg;
        end
    end

    // Square root chain, one root bit per cell.
    assign w_sv[0]    = r_sum_valid;
    assign w_ssum[0]  = r_sum;
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_smag[0]  = r_sum_mag;
    assign w_sneg[0]  = r_sum_neg;

    for (genvar g = 0; g < CW; g++) begin : g_sqrt
        vn_sqrt_cell #(.CW(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[g]),
            .i_sum   (w_ssum[g]),
            .i_rem   (w_srem[g]),
            .i_root  (w_sroot[g]),
            .i_mag   (w_smag[g]),
            .i_neg   (w_sneg[g]),
            .o_valid (w_sv[g+1]),
            .o_sum   (w_ssum[g+1]),
            .o_rem   (w_srem[g+1]),
            .o_root  (w_sroot[g+1]),
            .o_mag   (w_smag[g+1]),
            .o_neg   (w_sneg[g+1])
        );
    end

    // Divider chain, one quotient bit for each lane per cell.
    assign w_dv[0]   = w_sv[CW];
    assign w_dlen[0] = w_sroot[CW];
    assign w_dneg[0] = w_sneg[CW];
    assign w_dquo[0] = '0;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_drem[0][i] = {1'b0, w_smag[CW][i]};
        end
    end

    for (genvar g = 0; g <= FB; g++) begin : g_div
        vn_div_cell #(.CW(CW), .FB(FB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_len   (w_dlen[g]),
            .i_rem   (w_drem[g]),
            .i_quo   (w_dquo[g]),
            .i_neg   (w_dneg[g]),
            .o_valid (w_dv[g+1]),
            .o_len   (w_dlen[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_quo   (w_dquo[g+1]),
            .o_neg   (w_dneg[g+1])
        );
    end

    // Sign applied to each quotient; the zero vector forces all fields to zero.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_unit[i] = w_dneg[FB+1][i] ? (FW'(0) - FW'(w_dquo[FB+1][i]))
                                        : FW'(w_dquo[FB+1][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv[FB+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero    <= (w_dlen[FB+1] == '0);
            r_mag_out <= FW'(w_dlen[FB+1]);
            r_unit    <= (w_dlen[FB+1] == '0) ? '0 : w_unit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_mag_out, r_unit[2], r_unit[1], r_unit[0]};
    assign m_axis_tuser  = r_zero;

endmodule

[sv/vn_checker.sv]
`include "vector3_normalize_defines.svh"

module vn_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [vn_pkg::VN_OUT_DATA_WIDTH-1:0] m_axis_tdata,
    input logic                                 m_axis_tuser
);
    import vn_pkg::*;

    localparam int unsigned FW = VN_FIELD_WIDTH;

    // A zero vector transaction carries all-zero fields.
    `VN_ASSERT_IMP(a_zero_fields, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    // A nonzero vector has a nonzero length.
    `VN_ASSERT_IMP(a_len_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[4*FW-1 -: FW] != '0)
    // A stalled result transaction holds.
    `VN_ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready,
        ##1 (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    // Reset empties the output.
    `VN_ASSERT_NEXT(a_reset_empty, !i_rst_n, !m_axis_tvalid)

endmodule

bind vector3_normalize vn_checker u_vn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
